FILE: rtl/sha_pkg.sv
package sha_pkg;

  localparam int unsigned LenBits = 61;

  typedef enum logic [0:0] {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // Block handed from the buffer to the compression core.
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } job_t;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: rtl/sha_if.sv
interface sha_in_if;
  import sha_pkg::*;
  logic  valid;
  logic  ready;
  cmd_t  cmd;
  logic [7:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sha_front.sv
// Shifts bytes into a 64-byte block register and appends the padding one
// byte per cycle when the handoff is free; full blocks go to the core.
module sha_front import sha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  sha_in_if.sink in,
  output logic  job_valid,
  input  logic  job_ready,
  output job_t  job
);

  typedef enum logic [2:0] {
    S_FILL = 3'b001,
    S_PAD  = 3'b010,
    S_LEN  = 3'b100
  } fstate_t;

  fstate_t      state;
  logic [511:0] blk;
  logic [5:0]   fill_count;
  logic [LenBits-1:0] message_bytes;
  logic [63:0]  len_bytes;
  logic         pad_first;
  logic         job_pend;
  logic         accept;
  logic         slot_free;
  logic         ins;
  logic [7:0]   ins_byte;
  logic         job_load;

  assign in.ready  = (state == S_FILL) && !job_pend;
  assign accept    = in.valid && in.ready;
  assign job_valid = job_pend;
  // the byte that completes a block needs the handoff register
  assign slot_free = (fill_count != 6'd63) || !job_pend || job_ready;

  always_comb begin
    ins = 1'b0;
    ins_byte = in.data_byte;
    case (state)
      S_FILL: ins = accept && (in.cmd == CMD_ABSORB);
      S_PAD: begin
        ins = slot_free;
        ins_byte = pad_first ? 8'h80 : 8'h00;
      end
      S_LEN: begin
        ins = slot_free;
        ins_byte = len_bytes[63:56];
      end
      default: ins = 1'b0;
    endcase
  end

  assign job_load = ins && (fill_count == 6'd63);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill_count <= '0;
      message_bytes <= '0;
      job_pend <= 1'b0;
    end else begin
      if (job_load) begin
        job_pend <= 1'b1;
      end else if (job_ready) begin
        job_pend <= 1'b0;
      end
      if (ins) begin
        blk <= {blk[503:0], ins_byte};
        fill_count <= fill_count + 6'd1;
      end
      if (job_load) begin
        job.block <= {blk[503:0], ins_byte};
        job.last  <= (state == S_LEN);
      end
      case (state)
        S_FILL: begin
          if (accept) begin
            if (in.cmd == CMD_ABSORB) begin
              message_bytes <= message_bytes + LenBits'(1);
            end else begin
              len_bytes <= {message_bytes, 3'b000};
              pad_first <= 1'b1;
              message_bytes <= '0;
              state <= S_PAD;
            end
          end
        end
        // 0x80 then zeros up to byte 55, wrapping through a block if needed
        S_PAD: begin
          if (ins) begin
            pad_first <= 1'b0;
            if (fill_count == 6'd55) state <= S_LEN;
          end
        end
        S_LEN: begin
          if (ins) begin
            len_bytes <= {len_bytes[55:0], 8'h00};
            if (fill_count == 6'd63) state <= S_FILL;
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

endmodule

FILE: rtl/sha_core.sv
// 64-round compression, one round per cycle; digest output follows the last block only.
module sha_core import sha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  job_valid,
  output logic  job_ready,
  input  job_t  job,
  sha_out_if.source out
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_OUT   = 3'b100
  } cstate_t;

  cstate_t state;
  word_t   h [8];
  word_t   a, b, c, d, e, f, g, hh;
  word_t   w [16];
  logic [5:0] rnd;
  logic    last;
  logic [2:0] idx;
  word_t   t1, t2, s0, s1, w_new;

  assign job_ready = (state == C_IDLE);

  always_comb begin
    t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(rnd) + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = w[0] + s0 + w[9] + s1;
  end

  assign out.valid       = (state == C_OUT);
  assign out.digest_word = h[idx];
  assign out.word_index  = idx;
  assign out.last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
      rnd <= '0;
      idx <= '0;
    end else begin
      case (state)
        C_IDLE: begin
          if (job_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= job.block[511-32*i -: 32];
            {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
            last  <= job.last;
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          hh <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            h[0] <= h[0] + t1 + t2; h[1] <= h[1] + a; h[2] <= h[2] + b;
            h[3] <= h[3] + c;       h[4] <= h[4] + d + t1; h[5] <= h[5] + e;
            h[6] <= h[6] + f;       h[7] <= h[7] + g;
            idx   <= '0;
            state <= last ? C_OUT : C_IDLE;
          end
        end
        C_OUT: begin
          if (out.ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
              state <= C_IDLE;
            end
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sha256_byte_stream_hash.sv
// SHA-256 over a byte stream. Absorb transfers are accepted one per cycle,
// pausing after every 64th byte until the core takes the block; the core
// compresses each block while the front fills the next block.
// A finish appends the padding one byte per cycle while the block handoff is
// free; the digest words then follow one per cycle while out.ready is high.
// Synchronous active-high reset returns the initial hash and an empty buffer.
module sha256_byte_stream_hash import sha_pkg::*; (
  input  logic clk,
  input  logic rst,
  sha_in_if.sink  in,
  sha_out_if.source out
);

  logic job_valid;
  logic job_ready;
  job_t job;

  sha_front u_front (
    .clk, .rst, .in,
    .job_valid, .job_ready, .job
  );

  sha_core u_core (
    .clk, .rst,
    .job_valid, .job_ready, .job,
    .out
  );

endmodule
